[hdl/urrc_pkg.sv]
// Shared types, constants and slot arithmetic for the undo/redo ring controller.
package urrc_pkg;

  localparam int SlotCount    = 8;
  localparam int SlotsPerBank = 4;
  localparam int PtrW         = $clog2(SlotCount);
  localparam int SlotNumW     = 5;
  localparam int CountW       = 4;
  localparam int BankSlotW    = 2;

  localparam logic [CountW-1:0] CountMax   = 4'd15;
  localparam logic [CountW-1:0] LimitReset = 4'd7;

  typedef enum logic [1:0] {
    OP_SNAPSHOT = 2'd0,
    OP_UNDO     = 2'd1,
    OP_REDO     = 2'd2
  } op_e;

  typedef struct packed {
    op_e  operation;
    logic with_redo_save;
  } in_item_t;

  typedef struct packed {
    logic                 acted;
    logic                 save_valid;
    logic                 save_bank;
    logic [BankSlotW-1:0] save_index;
    logic                 restore_valid;
    logic                 restore_bank;
    logic [BankSlotW-1:0] restore_slot;
    logic [CountW-1:0]    undo_available;
    logic [CountW-1:0]    redo_available;
  } out_item_t;

  typedef struct packed {
    logic [PtrW-1:0]   ptr;
    logic [CountW-1:0] undo_depth;
    logic [CountW-1:0] redo_depth;
  } ring_state_t;

  typedef struct packed {
    logic                 bank;
    logic [BankSlotW-1:0] slot;
  } slot_loc_t;

  function automatic logic [PtrW-1:0] slot_after(logic [PtrW-1:0] p);
    logic [SlotNumW-1:0] pw;
    pw = SlotNumW'(p);
    if (pw >= SlotNumW'(SlotCount - 1)) begin
      return '0;
    end
    return PtrW'(pw + SlotNumW'(1));
  endfunction

  function automatic logic [PtrW-1:0] slot_before(logic [PtrW-1:0] p);
    logic [SlotNumW-1:0] pw;
    pw = SlotNumW'(p);
    if (pw == '0 || pw >= SlotNumW'(SlotCount)) begin
      return PtrW'(SlotCount - 1);
    end
    return PtrW'(pw - SlotNumW'(1));
  endfunction

  function automatic slot_loc_t split_slot(logic [PtrW-1:0] p);
    slot_loc_t           loc;
    logic [SlotNumW-1:0] pw;
    logic [SlotNumW-1:0] rel;
    pw = SlotNumW'(p);
    if (pw >= SlotNumW'(SlotsPerBank)) begin
      rel      = pw - SlotNumW'(SlotsPerBank);
      loc.bank = 1'b1;
    end else begin
      rel      = pw;
      loc.bank = 1'b0;
    end
    loc.slot = rel[BankSlotW-1:0];
    return loc;
  endfunction

  function automatic logic [CountW-1:0] inc_sat(logic [CountW-1:0] v);
    return (v < CountMax) ? v + CountW'(1) : CountMax;
  endfunction

endpackage

[hdl/undo_redo_ring_controller_core.sv]
// A result is loaded into the output register when its item is accepted.
// Throughput: one item per cycle while the output register can take it; pointer and counts update per item.
// A stalled result holds in the output register and new items wait only while it is full.
// Reset clears the slot pointer and both counts and sets the undo limit to 7.
// The configuration write is always ready and takes effect on the next item.
module undo_redo_ring_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  urrc_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output urrc_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [urrc_pkg::CountW-1:0] cfg_data_i
);

  urrc_pkg::ring_state_t       state_q;
  urrc_pkg::ring_state_t       state_d;
  logic [urrc_pkg::CountW-1:0] limit_q;
  urrc_pkg::out_item_t         result;
  logic                        in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  urrc_step u_step (
    .state_i      (state_q),
    .undo_limit_i (limit_q),
    .item_i       (in_data_i),
    .state_o      (state_d),
    .result_o     (result)
  );

  urrc_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .data_i       (result),
    .load_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      limit_q <= urrc_pkg::LimitReset;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  a_snapshot_clears_redo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.operation == urrc_pkg::OP_SNAPSHOT |=> state_q.redo_depth == '0)
    else $error("snapshot did not clear the redo count");

  a_empty_undo_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.operation == urrc_pkg::OP_UNDO && state_q.undo_depth == '0
    |=> $stable(state_q) && !out_data_o.acted)
    else $error("undo with nothing to undo changed state");

  a_restore_needs_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.restore_valid || out_data_o.save_valid) |-> out_data_o.acted)
    else $error("slot named by an item that did not act");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    urrc_pkg::SlotNumW'(state_q.ptr) < urrc_pkg::SlotNumW'(urrc_pkg::SlotCount))
    else $error("slot pointer left the ring");

  a_counts_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_data_o.undo_available == state_q.undo_depth
                  && out_data_o.redo_available == state_q.redo_depth)
    else $error("reported counts differ from the stored counts");

endmodule

[hdl/urrc_step.sv]
// Combinational next-state and result logic for one undo/redo/snapshot item.
module urrc_step (
  input  urrc_pkg::ring_state_t       state_i,
  input  logic [urrc_pkg::CountW-1:0] undo_limit_i,
  input  urrc_pkg::in_item_t          item_i,
  output urrc_pkg::ring_state_t       state_o,
  output urrc_pkg::out_item_t         result_o
);

  urrc_pkg::slot_loc_t        save_loc;
  urrc_pkg::slot_loc_t        restore_loc;
  logic [urrc_pkg::PtrW-1:0]  ptr_back;
  logic [urrc_pkg::PtrW-1:0]  ptr_fwd;

  assign ptr_back = urrc_pkg::slot_before(state_i.ptr);
  assign ptr_fwd  = urrc_pkg::slot_after(state_i.ptr);

  always_comb begin
    state_o     = state_i;
    result_o    = '0;
    save_loc    = '0;
    restore_loc = '0;
    case (item_i.operation)
      urrc_pkg::OP_SNAPSHOT: begin
        result_o.acted      = 1'b1;
        result_o.save_valid = 1'b1;
        save_loc            = urrc_pkg::split_slot(state_i.ptr);
        state_o.redo_depth  = '0;
        if (state_i.undo_depth < undo_limit_i) begin
          state_o.undo_depth = state_i.undo_depth + urrc_pkg::CountW'(1);
        end
        state_o.ptr = ptr_fwd;
      end
      urrc_pkg::OP_UNDO: begin
        if (state_i.undo_depth != '0) begin
          result_o.acted = 1'b1;
          // With a redo save requested, the first undo after a run of edits keeps the live image for redo.
          if (item_i.with_redo_save) begin
            if (state_i.redo_depth == '0) begin
              result_o.save_valid = 1'b1;
              save_loc            = urrc_pkg::split_slot(state_i.ptr);
            end
            state_o.redo_depth = urrc_pkg::inc_sat(state_i.redo_depth);
          end
          state_o.ptr            = ptr_back;
          result_o.restore_valid = 1'b1;
          restore_loc            = urrc_pkg::split_slot(ptr_back);
          state_o.undo_depth     = state_i.undo_depth - urrc_pkg::CountW'(1);
        end
      end
      urrc_pkg::OP_REDO: begin
        if (state_i.redo_depth != '0) begin
          result_o.acted         = 1'b1;
          result_o.restore_valid = 1'b1;
          restore_loc            = urrc_pkg::split_slot(ptr_fwd);
          state_o.redo_depth     = state_i.redo_depth - urrc_pkg::CountW'(1);
          state_o.undo_depth     = urrc_pkg::inc_sat(state_i.undo_depth);
          state_o.ptr            = ptr_fwd;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.save_bank      = save_loc.bank;
    result_o.save_index     = save_loc.slot;
    result_o.restore_bank   = restore_loc.bank;
    result_o.restore_slot   = restore_loc.slot;
    result_o.undo_available = state_o.undo_depth;
    result_o.redo_available = state_o.redo_depth;
  end

endmodule

[hdl/urrc_out_stage.sv]
// Output result register with valid/ready handshake.
module urrc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  urrc_pkg::out_item_t data_i,
  output logic                load_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output urrc_pkg::out_item_t out_data_o
);

  logic                valid_q;
  logic                valid_d;
  urrc_pkg::out_item_t data_q;

  // A new item may enter when the register is empty or the held one leaves in the same cycle.
  assign load_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
